// ----- rtl/bsc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants of the barometric compensation block
// Holds the payload structs, the sequencer states and the register indexes.
// ----------------------------------------------------------------------------
package bsc_pkg;

	localparam int RawW = 19;

	localparam logic [1:0] REG_CAL_A = 2'd0;
	localparam logic [1:0] REG_CAL_B = 2'd1;
	localparam logic [1:0] REG_CAL_C = 2'd2;
	localparam logic [1:0] REG_OSS   = 2'd3;

	localparam logic CMD_TEMP  = 1'b0;
	localparam logic CMD_PRESS = 1'b1;

	typedef struct packed {
		logic            cmd;
		logic [RawW-1:0] raw_reading;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               div_error;
	} out_item_t;

	// Multiply operand selections of the shared multiplier.
	typedef enum logic [3:0] {
		M_T_X1, M_P_SQ, M_P_X1, M_P_X2, M_P_X1B, M_P_X2B, M_P_B4, M_P_B7,
		M_P_PP, M_P_PX, M_P_P7
	} mop_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_T_MUL, ST_T_DEN, ST_T_DIV, ST_T_FIN,
		ST_P_B6, ST_P_SQ, ST_P_X1, ST_P_X2, ST_P_B3, ST_P_X1B, ST_P_X2B,
		ST_P_X3, ST_P_B4, ST_P_B7, ST_P_CHK, ST_P_DIV, ST_P_PP, ST_P_PX, ST_P_P7,
		ST_P_FIN, ST_OUT
	} state_t;

endpackage : bsc_pkg
`default_nettype wire

// ----- rtl/baro_sensor_compensation.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// baro_sensor_compensation: integer temperature and pressure compensation
// A small sequencer drives one 32x32 multiplier and one radix-2 divider.
// ----------------------------------------------------------------------------
// Each product goes through the single shared 32-bit multiplier in its own
// cycle, and each quotient through the shared restoring divider, which makes
// one quotient bit per cycle and then hands the quotient over. With a zero
// divisor the division is skipped. The block takes one item at a time;
// in_stall is high from acceptance until the result transfer, and the next
// item is taken in the cycle after it at the earliest. The result sits in
// an output register and is held while out_stall is high.
// Calibration writes are taken in any cycle and are meant to happen while idle.
module baro_sensor_compensation (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire  [1:0]           cfg_index,
	input  wire  [63:0]          cfg_data,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire  bsc_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  wire                  out_stall,
	output bsc_pkg::out_item_t   out_data
);

	logic [63:0] cal_a_q, cal_b_q;
	logic [31:0] cal_c_q;
	logic [1:0]  oss_q;
	logic [31:0] b5_q;

	bsc_pkg::state_t state_q, state_d;
	logic [31:0]     raw_q;
	logic [31:0]     b6_q, sq_q, x1_q, x2_q, b3_q, b4_q, b7_q, p_q, t_q;
	logic            err_q;

	// Calibration fields.
	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = {{16{cal_a_q[15]}}, cal_a_q[15:0]};
	assign ac2 = {{16{cal_a_q[31]}}, cal_a_q[31:16]};
	assign ac3 = {{16{cal_a_q[47]}}, cal_a_q[47:32]};
	assign ac4 = {16'd0, cal_a_q[63:48]};
	assign ac5 = {16'd0, cal_b_q[15:0]};
	assign ac6 = {16'd0, cal_b_q[31:16]};
	assign b1  = {{16{cal_b_q[47]}}, cal_b_q[47:32]};
	assign b2  = {{16{cal_b_q[63]}}, cal_b_q[63:48]};
	assign mc  = {{16{cal_c_q[15]}}, cal_c_q[15:0]};
	assign md  = {{16{cal_c_q[31]}}, cal_c_q[31:16]};

	function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
		asr = 32'($signed(x) >>> n);
	endfunction

	// Configuration register writes.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_a_q <= '0;
			cal_b_q <= '0;
			cal_c_q <= '0;
			oss_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bsc_pkg::REG_CAL_A: cal_a_q <= cfg_data;
				bsc_pkg::REG_CAL_B: cal_b_q <= cfg_data;
				bsc_pkg::REG_CAL_C: cal_c_q <= cfg_data[31:0];
				bsc_pkg::REG_OSS:   oss_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// Shared multiplier operand selection; the low 32 bits are kept.
	bsc_pkg::mop_t mop;
	logic [31:0] ma, mb;
	always_comb begin
		ma = x1_q;
		mb = x1_q;
		case (mop)
			bsc_pkg::M_T_X1:  begin ma = raw_q - ac6;       mb = ac5; end
			bsc_pkg::M_P_SQ:  begin ma = b6_q;              mb = b6_q; end
			bsc_pkg::M_P_X1:  begin ma = sq_q;              mb = b2; end
			bsc_pkg::M_P_X2:  begin ma = ac2;               mb = b6_q; end
			bsc_pkg::M_P_X1B: begin ma = ac3;               mb = b6_q; end
			bsc_pkg::M_P_X2B: begin ma = b1;                mb = sq_q; end
			bsc_pkg::M_P_B4:  begin ma = ac4;               mb = t_q; end
			bsc_pkg::M_P_B7:  begin ma = raw_q - b3_q;      mb = 32'd50000 >> oss_q; end
			bsc_pkg::M_P_PP:  begin ma = asr(p_q, 5'd8);    mb = asr(p_q, 5'd8); end
			bsc_pkg::M_P_PX:  begin ma = x1_q;              mb = 32'd3038; end
			bsc_pkg::M_P_P7:  begin ma = p_q;               mb = 32'd0 - 32'd7357; end
			default: ;
		endcase
	end
	logic [31:0] mfull;
	assign mfull = ma * mb;

	// Shared unsigned restoring divider, one quotient bit per cycle.
	logic        div_start, div_busy_q;
	logic [31:0] div_n, div_d, dq_q, dd_q;
	logic [31:0] dr_q;
	logic [5:0]  dcnt_q;
	logic [32:0] dtrial;
	assign dtrial = {dr_q, dq_q[31]} - {1'b0, dd_q};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			dcnt_q     <= '0;
		end else if (div_start) begin
			div_busy_q <= 1'b1;
			dcnt_q     <= 6'd32;
		end else if (div_busy_q) begin
			dcnt_q <= dcnt_q - 6'd1;
			if (dcnt_q == 6'd1) div_busy_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (div_start) begin
			dq_q <= div_n;
			dd_q <= div_d;
			dr_q <= '0;
		end else if (div_busy_q) begin
			if (!dtrial[32]) begin
				dr_q <= dtrial[31:0];
				dq_q <= {dq_q[30:0], 1'b1};
			end else begin
				dr_q <= {dr_q[30:0], dq_q[31]};
				dq_q <= {dq_q[30:0], 1'b0};
			end
		end
	end

	// Signed operands of the temperature division.
	logic [31:0] tnum, tden;
	assign tnum = mc << 11;
	assign tden = x1_q + md;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bsc_pkg::ST_IDLE:
				if (in_valid) state_d = in_data.cmd == bsc_pkg::CMD_TEMP ?
					bsc_pkg::ST_T_MUL : bsc_pkg::ST_P_B6;
			bsc_pkg::ST_T_MUL:  state_d = bsc_pkg::ST_T_DEN;
			bsc_pkg::ST_T_DEN:  state_d = tden == 32'd0 ? bsc_pkg::ST_T_FIN : bsc_pkg::ST_T_DIV;
			bsc_pkg::ST_T_DIV:  if (!div_busy_q) state_d = bsc_pkg::ST_T_FIN;
			bsc_pkg::ST_T_FIN:  state_d = bsc_pkg::ST_OUT;
			bsc_pkg::ST_P_B6:   state_d = bsc_pkg::ST_P_SQ;
			bsc_pkg::ST_P_SQ:   state_d = bsc_pkg::ST_P_X1;
			bsc_pkg::ST_P_X1:   state_d = bsc_pkg::ST_P_X2;
			bsc_pkg::ST_P_X2:   state_d = bsc_pkg::ST_P_B3;
			bsc_pkg::ST_P_B3:   state_d = bsc_pkg::ST_P_X1B;
			bsc_pkg::ST_P_X1B:  state_d = bsc_pkg::ST_P_X2B;
			bsc_pkg::ST_P_X2B:  state_d = bsc_pkg::ST_P_X3;
			bsc_pkg::ST_P_X3:   state_d = bsc_pkg::ST_P_B4;
			bsc_pkg::ST_P_B4:   state_d = bsc_pkg::ST_P_B7;
			bsc_pkg::ST_P_B7:   state_d = bsc_pkg::ST_P_CHK;
			bsc_pkg::ST_P_CHK:  state_d = b4_q == 32'd0 ? bsc_pkg::ST_OUT : bsc_pkg::ST_P_DIV;
			bsc_pkg::ST_P_DIV:  if (!div_busy_q) state_d = bsc_pkg::ST_P_PP;
			bsc_pkg::ST_P_PP:   state_d = bsc_pkg::ST_P_PX;
			bsc_pkg::ST_P_PX:   state_d = bsc_pkg::ST_P_P7;
			bsc_pkg::ST_P_P7:   state_d = bsc_pkg::ST_P_FIN;
			bsc_pkg::ST_P_FIN:  state_d = bsc_pkg::ST_OUT;
			bsc_pkg::ST_OUT:    if (!out_stall) state_d = bsc_pkg::ST_IDLE;
			default:            state_d = bsc_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		mop       = bsc_pkg::M_T_X1;
		div_start = 1'b0;
		div_n     = tnum[31] ? 32'd0 - tnum : tnum;
		div_d     = tden[31] ? 32'd0 - tden : tden;
		in_stall  = state_q != bsc_pkg::ST_IDLE;
		out_valid = state_q == bsc_pkg::ST_OUT;
		unique case (state_q)
			bsc_pkg::ST_T_DEN:  div_start = tden != 32'd0;
			bsc_pkg::ST_P_SQ:   mop = bsc_pkg::M_P_SQ;
			bsc_pkg::ST_P_X1:   mop = bsc_pkg::M_P_X1;
			bsc_pkg::ST_P_X2:   mop = bsc_pkg::M_P_X2;
			bsc_pkg::ST_P_X1B:  mop = bsc_pkg::M_P_X1B;
			bsc_pkg::ST_P_X2B:  mop = bsc_pkg::M_P_X2B;
			bsc_pkg::ST_P_B4:   mop = bsc_pkg::M_P_B4;
			bsc_pkg::ST_P_B7:   mop = bsc_pkg::M_P_B7;
			bsc_pkg::ST_P_CHK: begin
				div_start = b4_q != 32'd0;
				div_n     = b7_q[31] ? b7_q : b7_q << 1;
				div_d     = b4_q;
			end
			bsc_pkg::ST_P_PP:   mop = bsc_pkg::M_P_PP;
			bsc_pkg::ST_P_PX:   mop = bsc_pkg::M_P_PX;
			bsc_pkg::ST_P_P7:   mop = bsc_pkg::M_P_P7;
			default: ;
		endcase
	end

	// State register and the stored B5.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsc_pkg::ST_IDLE;
			b5_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == bsc_pkg::ST_T_FIN) b5_q <= x1_q + x2_q;
		end
	end

	// Datapath registers, at most one product per cycle.
	logic [31:0] x3a, x3b;
	assign x3a = x1_q + x2_q;
	assign x3b = asr(x1_q + x2_q + 32'd2, 5'd2);
	always_ff @(posedge clk) begin
		unique case (state_q)
			bsc_pkg::ST_IDLE: begin
				raw_q <= {13'd0, in_data.raw_reading};
				err_q <= 1'b0;
			end
			bsc_pkg::ST_T_MUL: x1_q <= asr(mfull[31:0], 5'd15);
			bsc_pkg::ST_T_DEN: begin
				x2_q <= '0;
				if (tden == 32'd0) err_q <= 1'b1;
			end
			bsc_pkg::ST_T_DIV:
				if (!div_busy_q)
					x2_q <= (tnum[31] != tden[31]) ? 32'd0 - dq_q : dq_q;
			bsc_pkg::ST_T_FIN:
				t_q <= err_q ? 32'd0 : asr(x1_q + x2_q + 32'd8, 5'd4);
			bsc_pkg::ST_P_B6:  b6_q <= b5_q - 32'd4000;
			bsc_pkg::ST_P_SQ:  sq_q <= asr(mfull[31:0], 5'd12);
			bsc_pkg::ST_P_X1:  x1_q <= asr(mfull[31:0], 5'd11);
			bsc_pkg::ST_P_X2:  x2_q <= asr(mfull[31:0], 5'd11);
			bsc_pkg::ST_P_B3:
				b3_q <= asr(((ac1 << 2) + x3a << oss_q) + 32'd2, 5'd2);
			bsc_pkg::ST_P_X1B: x1_q <= asr(mfull[31:0], 5'd13);
			bsc_pkg::ST_P_X2B: begin
				x2_q <= asr(mfull[31:0], 5'd16);
			end
			// X3 + 32768 is formed once the second X2 is registered.
			bsc_pkg::ST_P_X3:  t_q <= x3b + 32'd32768;
			bsc_pkg::ST_P_B4: begin
				// Operand t_q is loaded with X3 + 32768 in the cycle before.
				b4_q <= mfull[31:0] >> 15;
			end
			bsc_pkg::ST_P_B7: b7_q <= mfull[31:0];
			bsc_pkg::ST_P_CHK: begin
				if (b4_q == 32'd0) begin
					err_q <= 1'b1;
					t_q   <= '0;
				end
			end
			bsc_pkg::ST_P_DIV:
				if (!div_busy_q) p_q <= b7_q[31] ? dq_q << 1 : dq_q;
			bsc_pkg::ST_P_PP: x1_q <= mfull[31:0];
			bsc_pkg::ST_P_PX: x1_q <= asr(mfull[31:0], 5'd16);
			bsc_pkg::ST_P_P7: x2_q <= asr(mfull[31:0], 5'd16);
			bsc_pkg::ST_P_FIN:
				t_q <= p_q + asr(x1_q + x2_q + 32'd3791, 5'd4);
			default: ;
		endcase
	end

	assign out_data.value     = t_q;
	assign out_data.div_error = err_q;

endmodule : baro_sensor_compensation
`default_nettype wire

// ----- test/baro_sensor_compensation_chk.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// baro_sensor_compensation_chk: result checker for the compensation block
// Watches the configuration, input and output channels, computes the expected
// temperature or pressure for every accepted input transfer and compares it
// with the oldest pending result, field by field.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_chk (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_valid,
	input  wire                 cfg_ready,
	input  wire  [1:0]          cfg_index,
	input  wire  [63:0]         cfg_data,
	input  wire                 in_valid,
	input  wire                 in_stall,
	input  bsc_pkg::in_item_t   in_data,
	input  wire                 out_valid,
	input  wire                 out_stall,
	input  bsc_pkg::out_item_t  out_data,
	output int                  fail_count,
	output int                  pending_count
);

	logic [63:0] cal_a, cal_b;
	logic [31:0] cal_c;
	logic [1:0]  oss_sel;
	logic signed [31:0] b5_kept;
	bsc_pkg::out_item_t expected_q[$];

	function automatic logic signed [31:0] sx16(input logic [15:0] h);
		return {{16{h[15]}}, h};
	endfunction

	// Signed division truncating toward zero, wrapping on overflow.
	function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ma, mb, q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q  = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	// Computes one result and updates the kept B5 on temperature transfers.
	function automatic bsc_pkg::out_item_t compensate(input bsc_pkg::in_item_t it);
		bsc_pkg::out_item_t r;
		logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
		logic [31:0] ac4, ac5, ac6, raw, x1, x2, x3, den, b6, sq, b3, b4, b7, p;
		ac1 = sx16(cal_a[15:0]);  ac2 = sx16(cal_a[31:16]);
		ac3 = sx16(cal_a[47:32]); ac4 = {16'd0, cal_a[63:48]};
		ac5 = {16'd0, cal_b[15:0]}; ac6 = {16'd0, cal_b[31:16]};
		b1 = sx16(cal_b[47:32]);  b2 = sx16(cal_b[63:48]);
		mc = sx16(cal_c[15:0]);   md = sx16(cal_c[31:16]);
		raw = {13'd0, it.raw_reading};
		r.value = 0;
		r.div_error = 1'b0;
		if (it.cmd == bsc_pkg::CMD_TEMP) begin
			x1 = $signed((raw - ac6) * ac5) >>> 15;
			den = x1 + md;
			x2 = 0;
			if (den == 0)
				r.div_error = 1'b1;
			else
				x2 = div_trunc(mc << 11, den);
			b5_kept = x1 + x2;
			if (!r.div_error)
				r.value = $signed(b5_kept + 32'd8) >>> 4;
		end else begin
			b6 = b5_kept - 32'd4000;
			sq = $signed(b6 * b6) >>> 12;
			x1 = $signed(sq * b2) >>> 11;
			x2 = $signed(ac2 * b6) >>> 11;
			x3 = x1 + x2;
			b3 = $signed(((ac1 * 4 + x3) << oss_sel) + 32'd2) >>> 2;
			x1 = $signed(ac3 * b6) >>> 13;
			x2 = $signed(b1 * sq) >>> 16;
			x3 = $signed(x1 + x2 + 32'd2) >>> 2;
			b4 = (ac4 * (x3 + 32'd32768)) >> 15;
			b7 = (raw - b3) * (32'd50000 >> oss_sel);
			if (b4 == 0) begin
				r.div_error = 1'b1;
			end else begin
				p = b7[31] ? ((b7 / b4) << 1) : ((b7 << 1) / b4);
				x1 = $signed(p) >>> 8;
				x1 = x1 * x1;
				x1 = $signed(x1 * 32'd3038) >>> 16;
				x2 = $signed(p * (32'd0 - 32'd7357)) >>> 16;
				// The final correction is shifted on its own so the shift stays
				// arithmetic.
				x3 = $signed(x1 + x2 + 32'd3791) >>> 4;
				r.value = p + x3;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bsc_pkg::out_item_t want;
		int errs;
		errs = 0;
		if (!arst_n) begin
			cal_a <= '0;
			cal_b <= '0;
			cal_c <= '0;
			oss_sel <= '0;
			b5_kept = 0;
			fail_count <= 0;
			pending_count <= 0;
			expected_q.delete();
		end else begin
			// Register writes mirror the block's configuration.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bsc_pkg::REG_CAL_A: cal_a <= cfg_data;
					bsc_pkg::REG_CAL_B: cal_b <= cfg_data;
					bsc_pkg::REG_CAL_C: cal_c <= cfg_data[31:0];
					bsc_pkg::REG_OSS:   oss_sel <= cfg_data[1:0];
					default: ;
				endcase
			end
			// An accepted input transfer queues its expected result.
			if (in_valid && !in_stall)
				expected_q.push_back(compensate(in_data));
			// An accepted output transfer is checked against the oldest one.
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result transfer: value %0d", out_data.value);
					errs++;
				end else begin
					want = expected_q.pop_front();
					if (want.value !== out_data.value) begin
						$error("value: expected %0d, got %0d", want.value, out_data.value);
						errs++;
					end
					if (want.div_error !== out_data.div_error) begin
						$error("div_error: expected %0b, got %0b",
							want.div_error, out_data.div_error);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending_count <= expected_q.size();
		end
	end

endmodule : baro_sensor_compensation_chk

// ----- test/baro_sensor_compensation_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// baro_sensor_compensation_tb: stimulus and verdict for the compensation block
// Programs several calibration sets, sends directed then random temperature
// and pressure readings under varying idle and stall patterns, and reports.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_tb;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	bsc_pkg::in_item_t  in_data;
	logic        out_valid;
	logic        out_stall = 1'b0;
	bsc_pkg::out_item_t out_data;
	int          fail_count;
	int          pending_count;
	int          send_idle_pct;
	int          recv_stall_pct;

	baro_sensor_compensation u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	baro_sensor_compensation_chk u_chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

	// Receiver stalls at random according to the current phase.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_reading(input logic cmd, input logic [18:0] raw);
		while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		in_valid <= 1'b1;
		in_data  <= {cmd, raw};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every result has arrived, then lets the block settle.
	task automatic drain();
		while (pending_count != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic load_cal(input logic [63:0] a, input logic [63:0] b,
			input logic [31:0] c, input logic [1:0] oss);
		write_reg(bsc_pkg::REG_CAL_A, a);
		write_reg(bsc_pkg::REG_CAL_B, b);
		write_reg(bsc_pkg::REG_CAL_C, {32'd0, c});
		write_reg(bsc_pkg::REG_OSS, {62'd0, oss});
	endtask

	// Realistic coefficients with a small random spread.
	task automatic load_typical(input logic [1:0] oss);
		logic [15:0] j;
		j = 16'($urandom_range(63));
		load_cal({16'd32741 + j, -16'sd14383, -16'sd1230 + j, 16'd408 + j},
			{-16'sd32768 + j, 16'd4, 16'd18000 + j, 16'd24000 + j},
			{16'd2868 + j, -16'sd8711 + j}, oss);
	endtask

	initial begin
		int phase;
		int n;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pressure before any temperature, zero calibration: zero divisors.
		send_reading(bsc_pkg::CMD_PRESS, 19'd0);
		send_reading(bsc_pkg::CMD_TEMP, 19'h7FFFF);
		send_reading(bsc_pkg::CMD_PRESS, 19'h7FFFF);
		drain();

		// Typical coefficients, typical and extreme readings, every oversampling value.
		for (int o = 0; o < 4; o++) begin
			load_typical(2'(o));
			send_reading(bsc_pkg::CMD_TEMP, 19'd27898);
			send_reading(bsc_pkg::CMD_PRESS, 19'd23843);
			send_reading(bsc_pkg::CMD_TEMP, 19'd0);
			send_reading(bsc_pkg::CMD_PRESS, 19'h7FFFF);
			drain();
		end

		// Temperature divisor zero: MD cancels X1 (AC5 = 0 makes X1 zero).
		load_cal(64'hFFFF_8000_8000_7FFF, 64'h7FFF_8000_0000_0000,
			32'h0000_8000, 2'd3);
		send_reading(bsc_pkg::CMD_TEMP, 19'd100);
		send_reading(bsc_pkg::CMD_PRESS, 19'd1);
		drain();

		// Extreme coefficients with small negative temperature divisors.
		load_cal(64'hFFFF_7FFF_7FFF_8000, 64'h8000_7FFF_0000_0000,
			32'hFFFF_0000 | 32'h0000_0000, 2'd0);
		write_reg(bsc_pkg::REG_CAL_C, {32'd0, 16'hFFFF, 16'h0000});
		write_reg(bsc_pkg::REG_CAL_C, {32'd0, 16'hFFFF, 16'h0010});
		send_reading(bsc_pkg::CMD_TEMP, 19'd5);
		send_reading(bsc_pkg::CMD_PRESS, 19'd40000);
		drain();
		write_reg(bsc_pkg::REG_CAL_C, {32'd0, 16'hFFFF, 16'h0000 | 16'h0000});
		// Most negative MC gives the largest dividend magnitude.
		write_reg(bsc_pkg::REG_CAL_C, {32'd0, 16'hFFFF, 16'h8000});
		write_reg(bsc_pkg::REG_CAL_B, 64'h0000_0000_0000_0000);
		send_reading(bsc_pkg::CMD_TEMP, 19'd0);
		send_reading(bsc_pkg::CMD_PRESS, 19'd300000);
		drain();

		// Random phases: no idling, sender idle, receiver stall, both.
		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			if (phase % 2 == 0)
				load_typical(2'($urandom_range(3)));
			else
				load_cal({$urandom, $urandom}, {$urandom, $urandom}, $urandom,
					2'($urandom_range(3)));
			for (n = 0; n < 200; n++) begin
				// Mostly temperature then pressure pairs, mostly plausible temperature words.
				if ($urandom_range(9) < 7) begin
					send_reading(bsc_pkg::CMD_TEMP, ($urandom_range(3) == 0) ?
						19'($urandom) : 19'($urandom_range(35000, 20000)));
					send_reading(bsc_pkg::CMD_PRESS, 19'($urandom));
					n++;
				end else begin
					send_reading(1'($urandom), 19'($urandom));
				end
			end
			drain();
		end

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule : baro_sensor_compensation_tb

// ----- filelist.f -----
rtl/bsc_pkg.sv
rtl/baro_sensor_compensation.sv
test/baro_sensor_compensation_chk.sv
test/baro_sensor_compensation_tb.sv
